// ----- rtl/glyph_cache_shelf_packer_core_macros.svh -----
// assertion macros for the glyph cache shelf packer
// used by glyph_cache_shelf_packer_core.sv, no other dependencies
`ifndef GLYPH_CACHE_SHELF_PACKER_CORE_MACROS_SVH
`define GLYPH_CACHE_SHELF_PACKER_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define GCSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define GCSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gcsp_pkg.sv -----
// shared constants for the glyph cache shelf packer
// no dependencies
package gcsp_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int POS_BITS_DEF = 12;

    localparam int CODE_W  = 21;
    localparam int GLYPH_W = 8;
    localparam int ATLAS_W = 13;
    localparam int ROWH_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [ATLAS_W-1:0] MAX_ATLAS       = 13'd4096;
    localparam logic [ATLAS_W-1:0] ATLAS_W_RESET   = 13'd1024;
    localparam logic [ATLAS_W-1:0] ATLAS_H_RESET   = 13'd1024;
    localparam logic [ROWH_W-1:0]  ROW_H_RESET     = 8'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_HEIGHT   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage

// ----- rtl/glyph_cache_shelf_packer_core.sv -----
// glyph cache with shelf packing into one texture atlas
// depends on gcsp_pkg and glyph_cache_shelf_packer_core_macros.svh
//
// Each request carries a character code with a glyph width and height and returns exactly one
// result. The placed glyphs live in a single-port-read synchronous table memory that is
// searched one entry per cycle in table order; the first matching code returns its stored
// placement with hit set. On a miss the glyph goes at the cursor if it fits the current row,
// else at x 0 of a new row one row height down; if neither fits, or the table is full, the
// result has placed_ok clear and all positions zero. A request is accepted only while idle, so
// one item is searched and placed before the next is taken. A finished result waits in the
// output register while the next item is taken. No clearing pass: only stored entries are ever
// compared. Configuration is to be written by the user only while idle; the block itself does
// not enforce this.
module glyph_cache_shelf_packer_core #(
    parameter int ENTRIES  = gcsp_pkg::ENTRIES_DEF,
    parameter int POS_BITS = gcsp_pkg::POS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [gcsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gcsp_pkg::ATLAS_W-1:0]     i_cfg_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // fields from bit 0: char_code, glyph_width, glyph_height, zero pad
    input  logic [39:0]                      s_axis_tdata,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // fields from bit 0: pos_x, pos_y, out_width, out_height, zero pad
    output logic [((2*POS_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // fields from bit 0: hit, placed_ok
    output logic [1:0]                       m_axis_tuser
);

`include "glyph_cache_shelf_packer_core_macros.svh"

    localparam int CW  = gcsp_pkg::CODE_W;
    localparam int GW  = gcsp_pkg::GLYPH_W;
    localparam int AW  = gcsp_pkg::ATLAS_W;
    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW  = $clog2(ENTRIES + 1);
    localparam int EW  = CW + 2*POS_BITS + 2*GW;
    localparam int ODW = ((2*POS_BITS+16+7)/8)*8;

    // entry layout from bit 0: height, width, y, x, code
    localparam int E_H = 0;
    localparam int E_W = GW;
    localparam int E_Y = 2*GW;
    localparam int E_X = 2*GW + POS_BITS;
    localparam int E_C = 2*GW + 2*POS_BITS;

    // configuration
    logic [AW-1:0] r_atlas_w, r_atlas_h;
    logic [7:0]    r_row_h;
    logic [AW-1:0] cfg_sat;

    // control
    gcsp_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_count, n_count;
    logic [AW-1:0] r_cursor_x, n_cursor_x, r_cursor_y, n_cursor_y;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_chk_last, n_chk_last;

    // request payload
    logic [CW-1:0] r_code, n_code;
    logic [GW-1:0] r_gw, n_gw, r_gh, n_gh;

    // result holding
    logic                r_res_hit, n_res_hit, r_res_ok, n_res_ok;
    logic [POS_BITS-1:0] r_res_x, n_res_x, r_res_y, n_res_y;
    logic [GW-1:0]       r_res_w, n_res_w, r_res_h, n_res_h;

    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, r_out_ok;
    logic [POS_BITS-1:0] r_out_x, r_out_y;
    logic [GW-1:0]       r_out_w, r_out_h;

    // table memory
    logic [EW-1:0] r_mem [ENTRIES];
    logic [EW-1:0] r_rd_data;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [EW-1:0] wr_data;

    logic          in_acc, out_load, full, fit_row, fit_new, place;
    logic [AW:0]   row_end, new_top, new_bot;
    logic [15:0]   cx16, cy16, nt16;
    logic [POS_BITS-1:0] place_x, place_y;

    assign s_axis_tready = (r_state == gcsp_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign cfg_sat = (i_cfg_data > gcsp_pkg::MAX_ATLAS) ? gcsp_pkg::MAX_ATLAS : i_cfg_data;

    // shelf rule arithmetic, one bit wider than the atlas registers
    assign full    = (r_count >= NW'(ENTRIES));
    assign row_end = {1'b0, r_cursor_x} + (AW+1)'(r_gw);
    assign fit_row = (row_end <= {1'b0, r_atlas_w});
    assign new_top = {1'b0, r_cursor_y} + (AW+1)'(r_row_h);
    assign new_bot = new_top + (AW+1)'(r_row_h);
    assign fit_new = (new_bot <= {1'b0, r_atlas_h}) && ((AW)'(r_gw) <= r_atlas_w);
    assign place   = !full && (fit_row || fit_new);

    assign cx16 = 16'(r_cursor_x);
    assign cy16 = 16'(r_cursor_y);
    assign nt16 = 16'(new_top);
    assign place_x = fit_row ? cx16[POS_BITS-1:0] : '0;
    assign place_y = fit_row ? cy16[POS_BITS-1:0] : nt16[POS_BITS-1:0];

    assign wr_data = {r_code, place_x, place_y, r_gw, r_gh};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_idx       = r_idx;
        n_chk_last  = r_chk_last;
        n_code      = r_code;
        n_gw        = r_gw;
        n_gh        = r_gh;
        n_res_hit   = r_res_hit;
        n_res_ok    = r_res_ok;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_w     = r_res_w;
        n_res_h     = r_res_h;
        rd_addr     = r_idx;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            gcsp_pkg::S_IDLE: begin
                rd_addr = '0;
                if (in_acc) begin
                    n_code     = s_axis_tdata[CW-1:0];
                    n_gw       = s_axis_tdata[CW+GW-1:CW];
                    n_gh       = s_axis_tdata[CW+2*GW-1:CW+GW];
                    n_idx      = IW'(1);
                    n_chk_last = (r_count == NW'(1));
                    n_state    = (r_count == '0) ? gcsp_pkg::S_DECIDE : gcsp_pkg::S_SEARCH;
                end
            end
            gcsp_pkg::S_SEARCH: begin
                // r_rd_data holds the entry issued on the previous cycle
                if (r_rd_data[E_C+CW-1:E_C] == r_code) begin
                    n_res_hit = 1'b1;
                    n_res_ok  = 1'b1;
                    n_res_x   = r_rd_data[E_X+POS_BITS-1:E_X];
                    n_res_y   = r_rd_data[E_Y+POS_BITS-1:E_Y];
                    n_res_w   = r_rd_data[E_W+GW-1:E_W];
                    n_res_h   = r_rd_data[E_H+GW-1:E_H];
                    n_state   = gcsp_pkg::S_FINISH;
                end else if (r_chk_last) begin
                    n_state = gcsp_pkg::S_DECIDE;
                end else begin
                    n_idx      = r_idx + IW'(1);
                    n_chk_last = (NW'(r_idx) == r_count - NW'(1));
                end
            end
            gcsp_pkg::S_DECIDE: begin
                n_res_hit = 1'b0;
                n_res_ok  = place;
                n_res_x   = place ? place_x : '0;
                n_res_y   = place ? place_y : '0;
                n_res_w   = place ? r_gw : '0;
                n_res_h   = place ? r_gh : '0;
                if (place) begin
                    // the new entry is read no earlier than the next item's search
                    mem_we  = 1'b1;
                    n_count = r_count + NW'(1);
                    if (fit_row) begin
                        n_cursor_x = row_end[AW-1:0];
                    end else begin
                        n_cursor_x = AW'(r_gw);
                        n_cursor_y = new_top[AW-1:0];
                    end
                end
                n_state = gcsp_pkg::S_FINISH;
            end
            gcsp_pkg::S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = gcsp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gcsp_pkg::S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !m_axis_tready) || out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcsp_pkg::S_IDLE;
            r_count     <= '0;
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_idx       <= '0;
            r_chk_last  <= 1'b0;
            r_out_valid <= 1'b0;
            r_atlas_w   <= gcsp_pkg::ATLAS_W_RESET;
            r_atlas_h   <= gcsp_pkg::ATLAS_H_RESET;
            r_row_h     <= gcsp_pkg::ROW_H_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_idx       <= n_idx;
            r_chk_last  <= n_chk_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gcsp_pkg::CFG_ATLAS_WIDTH:  r_atlas_w <= cfg_sat;
                    gcsp_pkg::CFG_ATLAS_HEIGHT: r_atlas_h <= cfg_sat;
                    gcsp_pkg::CFG_ROW_HEIGHT:   r_row_h   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_gw      <= n_gw;
        r_gh      <= n_gh;
        r_res_hit <= n_res_hit;
        r_res_ok  <= n_res_ok;
        r_res_x   <= n_res_x;
        r_res_y   <= n_res_y;
        r_res_w   <= n_res_w;
        r_res_h   <= n_res_h;
        if (out_load) begin
            r_out_hit <= r_res_hit;
            r_out_ok  <= r_res_ok;
            r_out_x   <= r_res_x;
            r_out_y   <= r_res_y;
            r_out_w   <= r_res_w;
            r_out_h   <= r_res_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out_ok, r_out_hit};
    assign m_axis_tdata  = ODW'({r_out_h, r_out_w, r_out_y, r_out_x});

    `GCSP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NW'(ENTRIES),
        "entry count beyond table depth")
    `GCSP_ASSERT_NOW(a_search_nonempty, i_clk, i_rst_n, r_state == gcsp_pkg::S_SEARCH,
        r_count != '0, "search started on an empty table")
    `GCSP_ASSERT_NEXT(a_place_counts, i_clk, i_rst_n, r_state == gcsp_pkg::S_DECIDE && place,
        r_count == $past(r_count) + NW'(1) && r_res_ok && !r_res_hit,
        "placement not recorded")

endmodule

// ----- verif/glyph_cache_shelf_packer_checker.sv -----
// scoreboard for the glyph cache shelf packer: mirrors the table and cursor, compares results
// depends on gcsp_pkg; watches the config port and both stream channels of the core
`timescale 1ns / 1ps

module glyph_cache_shelf_packer_checker #(
    parameter int ENTRIES  = gcsp_pkg::ENTRIES_DEF,
    parameter int POS_BITS = gcsp_pkg::POS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gcsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gcsp_pkg::ATLAS_W-1:0]       i_cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // fields from bit 0: char_code, glyph_width, glyph_height, zero pad
    input  logic [39:0]                        s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // fields from bit 0: pos_x, pos_y, out_width, out_height, zero pad
    input  logic [((2*POS_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // fields from bit 0: hit, placed_ok
    input  logic [1:0]                         m_axis_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_hits,
    output int                                 o_placed,
    output int                                 o_refused
);

    typedef struct packed {
        logic [gcsp_pkg::CODE_W-1:0] code;
        logic [POS_BITS-1:0]         x;
        logic [POS_BITS-1:0]         y;
        logic [7:0]                  w;
        logic [7:0]                  h;
    } t_glyph_slot;

    typedef struct packed {
        logic                hit;
        logic                ok;
        logic [POS_BITS-1:0] x;
        logic [POS_BITS-1:0] y;
        logic [7:0]          w;
        logic [7:0]          h;
    } t_placement;

    t_glyph_slot  slots [ENTRIES];
    int unsigned  n_slots;
    int unsigned  cur_x;
    int unsigned  cur_y;
    int unsigned  atlas_w;
    int unsigned  atlas_h;
    int unsigned  row_h;
    t_placement   placement_q [$];

    function automatic int unsigned clamp_atlas(input logic [gcsp_pkg::ATLAS_W-1:0] v);
        return (v > gcsp_pkg::MAX_ATLAS) ? 32'(gcsp_pkg::MAX_ATLAS) : 32'(v);
    endfunction

    // search in table order, else pack onto the current shelf or open a new one, else refuse
    function automatic t_placement place_glyph(input logic [gcsp_pkg::CODE_W-1:0] code,
                                               input logic [7:0] gw, input logic [7:0] gh);
        t_placement  r;
        int unsigned new_top;
        int unsigned px;
        int unsigned py;
        r = '0;
        for (int i = 0; i < n_slots; i++) begin
            if (slots[i].code == code) begin
                r.hit = 1'b1;
                r.ok  = 1'b1;
                r.x   = slots[i].x;
                r.y   = slots[i].y;
                r.w   = slots[i].w;
                r.h   = slots[i].h;
                return r;
            end
        end
        if (n_slots >= ENTRIES)
            return r;
        new_top = cur_y + row_h;
        if (cur_x + gw <= atlas_w) begin
            px    = cur_x;
            py    = cur_y;
            cur_x = cur_x + gw;
        end else if (new_top + row_h <= atlas_h && gw <= atlas_w) begin
            px    = 0;
            py    = new_top;
            cur_x = 32'(gw);
            cur_y = new_top;
        end else begin
            return r;
        end
        // positions keep only their low bits, so a zero-width glyph at x 4096 lands on 0
        slots[n_slots].code = code;
        slots[n_slots].x    = POS_BITS'(px);
        slots[n_slots].y    = POS_BITS'(py);
        slots[n_slots].w    = gw;
        slots[n_slots].h    = gh;
        n_slots++;
        r.ok = 1'b1;
        r.x  = POS_BITS'(px);
        r.y  = POS_BITS'(py);
        r.w  = gw;
        r.h  = gh;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_placement want;
        if (!i_rst_n) begin
            n_slots      = 0;
            cur_x        = 0;
            cur_y        = 0;
            atlas_w      = 32'(gcsp_pkg::ATLAS_W_RESET);
            atlas_h      = 32'(gcsp_pkg::ATLAS_H_RESET);
            row_h        = 32'(gcsp_pkg::ROW_H_RESET);
            placement_q.delete();
            o_fail_count = 0;
            o_hits       = 0;
            o_placed     = 0;
            o_refused    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gcsp_pkg::CFG_ATLAS_WIDTH:  atlas_w = clamp_atlas(i_cfg_data);
                    gcsp_pkg::CFG_ATLAS_HEIGHT: atlas_h = clamp_atlas(i_cfg_data);
                    gcsp_pkg::CFG_ROW_HEIGHT:
                        row_h = 32'(i_cfg_data[gcsp_pkg::ROWH_W-1:0]);
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (placement_q.size() == 0) begin
                    $error("result item with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = placement_q.pop_front();
                    check_field("hit", 32'(want.hit), 32'(m_axis_tuser[0]));
                    check_field("placed_ok", 32'(want.ok), 32'(m_axis_tuser[1]));
                    check_field("pos_x", 32'(want.x), 32'(m_axis_tdata[POS_BITS-1:0]));
                    check_field("pos_y", 32'(want.y),
                                32'(m_axis_tdata[2*POS_BITS-1:POS_BITS]));
                    check_field("out_width", 32'(want.w),
                                32'(m_axis_tdata[2*POS_BITS+7:2*POS_BITS]));
                    check_field("out_height", 32'(want.h),
                                32'(m_axis_tdata[2*POS_BITS+15:2*POS_BITS+8]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = place_glyph(s_axis_tdata[20:0], s_axis_tdata[28:21],
                                   s_axis_tdata[36:29]);
                placement_q = {placement_q, want};
                if (want.hit)
                    o_hits++;
                else if (want.ok)
                    o_placed++;
                else
                    o_refused++;
            end
        end
        o_pending = placement_q.size();
    end

endmodule

// ----- verif/tb_glyph_cache_shelf_packer_core.sv -----
// stimulus and verdict for glyph_cache_shelf_packer_core
// depends on gcsp_pkg, the core and glyph_cache_shelf_packer_checker
`timescale 1ns / 1ps

module tb_glyph_cache_shelf_packer_core;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [gcsp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gcsp_pkg::ATLAS_W-1:0]   cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    // fields from bit 0: char_code, glyph_width, glyph_height, zero pad
    logic [39:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // fields from bit 0: pos_x, pos_y, out_width, out_height, zero pad
    logic [39:0]                    m_tdata;
    // fields from bit 0: hit, placed_ok
    logic [1:0]                     m_tuser;

    int                             fail_count;
    int                             pending;
    int                             n_hits;
    int                             n_placed;
    int                             n_refused;

    int                             n_sent;
    int                             n_writes;
    bit                             src_gaps;
    bit                             sink_gaps;
    bit                             held_off;
    logic [gcsp_pkg::CODE_W-1:0]    code_pool [$];

    glyph_cache_shelf_packer_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    glyph_cache_shelf_packer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_hits        (n_hits),
        .o_placed      (n_placed),
        .o_refused     (n_refused)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #50_000_000;
        $display("glyph_cache_shelf_packer_core regression: fail");
        $finish;
    end

    // result side: random stalls, plus one long hold-off so the core backs up
    initial begin
        m_tready = 1'b0;
        held_off = 1'b0;
        forever begin
            @(negedge clk);
            if (!held_off && n_sent >= 300) begin
                held_off = 1'b1;
                m_tready = 1'b0;
                repeat (600) @(negedge clk);
            end else if (sink_gaps && $urandom_range(0, 11) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    // registers only change once every result is back
    task automatic write_reg(input logic [gcsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gcsp_pkg::ATLAS_W-1:0] val);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        n_writes++;
    endtask

    task automatic set_atlas(input logic [gcsp_pkg::ATLAS_W-1:0] aw,
                             input logic [gcsp_pkg::ATLAS_W-1:0] ah,
                             input logic [gcsp_pkg::ATLAS_W-1:0] rh);
        write_reg(gcsp_pkg::CFG_ATLAS_WIDTH, aw);
        write_reg(gcsp_pkg::CFG_ATLAS_HEIGHT, ah);
        write_reg(gcsp_pkg::CFG_ROW_HEIGHT, rh);
    endtask

    task automatic send_glyph(input logic [gcsp_pkg::CODE_W-1:0] code, input logic [7:0] gw,
                              input logic [7:0] gh);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, gh, gw, code};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        code_pool = {code_pool, code};
        n_sent++;
    endtask

    // mostly repeats of known codes so the table fills slowly across the phases
    task automatic send_random_glyph();
        logic [gcsp_pkg::CODE_W-1:0] code;
        logic [7:0]                  gw;
        int                          pick;
        if (code_pool.size() != 0 && $urandom_range(0, 99) < 75)
            code = code_pool[$urandom_range(0, code_pool.size() - 1)];
        else
            code = 21'($urandom_range(0, 1114111));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            gw = 8'($urandom_range(0, 40));
        else if (pick < 9)
            gw = 8'($urandom_range(0, 255));
        else
            gw = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        send_glyph(code, gw, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_atlas();
        logic [gcsp_pkg::ATLAS_W-1:0] aw;
        logic [gcsp_pkg::ATLAS_W-1:0] ah;
        logic [gcsp_pkg::ATLAS_W-1:0] rh;
        case ($urandom_range(0, 5))
            0:       aw = 13'd1;
            1:       aw = 13'($urandom_range(4097, 8191));
            default: aw = 13'($urandom_range(512, 4096));
        endcase
        case ($urandom_range(0, 3))
            0:       ah = 13'($urandom_range(1, 4096));
            1:       ah = 13'd4096;
            default: ah = 13'($urandom_range(4097, 8191));
        endcase
        case ($urandom_range(0, 7))
            0:       rh = 13'd0;
            1:       rh = 13'($urandom_range(0, 8191));
            2:       rh = 13'd255;
            default: rh = 13'($urandom_range(1, 12));
        endcase
        set_atlas(aw, ah, rh);
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = gcsp_pkg::CFG_ATLAS_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        n_sent    = 0;
        n_writes  = 0;
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // oversized width saturates to 4096; fill the first shelf exactly to the edge
        write_reg(gcsp_pkg::CFG_ATLAS_WIDTH, 13'h1FFF);
        send_glyph(21'd0, 8'd255, 8'd0);
        send_glyph(21'd1114111, 8'd255, 8'd255);
        for (int i = 2; i < 16; i++)
            send_glyph(21'(32'h100 + i), 8'd255, 8'(i * 17));
        send_glyph(21'h1FFF, 8'd16, 8'd8);
        // zero-width glyph at x 4096 wraps to column 0
        send_glyph(21'h2000, 8'd0, 8'd3);
        // no room left on the shelf, and taller than the row
        send_glyph(21'h2001, 8'd1, 8'd200);
        send_glyph(21'd0, 8'd7, 8'd9);
        send_glyph(21'd1114111, 8'd1, 8'd1);
        send_glyph(21'h2000, 8'd99, 8'd99);
        s_tvalid = 1'b0;
        // zero-sized atlas: nothing fits, nothing is stored
        set_atlas(13'd0, 13'd0, 13'd0);
        send_glyph(21'h2002, 8'd0, 8'd5);
        send_glyph(21'h2002, 8'd10, 8'd5);
        s_tvalid = 1'b0;

        for (int p = 0; p < 12; p++) begin
            if (p == 0)
                set_atlas(13'd0, 13'd0, 13'd0);
            else if (p == 1)
                set_atlas(13'd4096, 13'h1FFF, 13'h1FFF);
            else if (p == 11) begin
                src_gaps  = 1'b0;
                sink_gaps = 1'b0;
                set_atlas(13'd4096, 13'd4096, 13'd1);
            end else
                random_atlas();
            repeat (160) send_random_glyph();
            s_tvalid = 1'b0;
        end

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        $display("%0d glyph requests: %0d hits, %0d new placements, %0d refused",
                 n_sent, n_hits, n_placed, n_refused);
        $display("%0d register writes across 14 atlas settings, one long result stall",
                 n_writes);
        if (fail_count == 0)
            $display("glyph_cache_shelf_packer_core regression: pass");
        else
            $display("glyph_cache_shelf_packer_core regression: fail");
        $finish;
    end

endmodule
